// ----- design/hrc_pkg.sv -----
// shared types and constants for the hysteresis rep counter
// used by hrc_cfg_regs, hrc_core and hysteresis_rep_counter
`default_nettype none

package hrc_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 16;
  localparam int TIME_BITS       = 32;
  localparam int ALPHA_W         = 9;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // 180 degrees in fixed point
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_UP_THR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_THR = 3'd5;

  // request codes
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef enum logic [1:0] {
    PH_UNKNOWN  = 2'd0,
    PH_FLEXED   = 2'd1,
    PH_EXTENDED = 2'd2
  } phase_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]    ext_threshold;
    logic [ANGLE_W-1:0]    flex_threshold;
    logic [15:0]           min_interval_ms;
    logic [15:0]           lost_timeout_ms;
    logic [ALPHA_W-1:0]    smoothing_alpha;
    logic [ANGLE_W-1:0]    partial_threshold;
  } cfg_t;

  typedef struct packed {
    logic                  req_type;
    logic                  reading_valid;
    logic [ANGLE_W-1:0]    angle;
    logic [TIME_BITS-1:0]  timestamp_ms;
  } item_t;

  typedef struct packed {
    logic                  rep_done;
    logic                  partial_rep;
    phase_t                phase;
    logic [ANGLE_W-1:0]    smoothed_angle;
    logic                  has_reading;
    logic                  ever_seen;
    logic [ANGLE_W-1:0]    last_rep_min_angle;
  } result_t;

endpackage

`default_nettype wire

// ----- design/hrc_cfg_regs.sv -----
// configuration register file of the hysteresis rep counter
// depends on hrc_pkg
`default_nettype none

module hrc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [hrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hrc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              cfg_ready,
  output hrc_pkg::cfg_t                     cfg
);
  import hrc_pkg::*;

  cfg_t cfg_r;

  // writes must be made only while idle (the block itself does not enforce this), so the port never needs to push back
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ext_threshold     <= 16'd40960;
      cfg_r.flex_threshold    <= 16'd25600;
      cfg_r.min_interval_ms   <= 16'd500;
      cfg_r.lost_timeout_ms   <= 16'd1000;
      cfg_r.smoothing_alpha   <= 9'd128;
      cfg_r.partial_threshold <= 16'd30720;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UP_THR:      cfg_r.ext_threshold     <= cfg_wdata;
        REG_DOWN_THR:    cfg_r.flex_threshold    <= cfg_wdata;
        REG_MIN_INT:     cfg_r.min_interval_ms   <= cfg_wdata;
        REG_LOST_TO:     cfg_r.lost_timeout_ms   <= cfg_wdata;
        REG_ALPHA:       cfg_r.smoothing_alpha   <= cfg_wdata[ALPHA_W-1:0];
        REG_PARTIAL_THR: cfg_r.partial_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/hrc_core.sv -----
// tracking state and per-item update: smoothing, phase hysteresis, rep debounce
// depends on hrc_pkg
`default_nettype none

module hrc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  hrc_pkg::item_t   item,
  input  hrc_pkg::cfg_t    cfg,
  output hrc_pkg::result_t res
);
  import hrc_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic                   sm_valid_r, sm_valid_nxt;
  logic [ANGLE_W-1:0]     smoothed_r, smoothed_nxt;
  logic [ANGLE_W-1:0]     rep_min_r, rep_min_nxt;
  logic [ANGLE_W-1:0]     last_min_r, last_min_nxt;
  logic [TIME_BITS-1:0]   rep_stamp_r, rep_stamp_nxt;
  logic                   rep_stamp_valid_r, rep_stamp_valid_nxt;
  logic [TIME_BITS-1:0]   read_stamp_r, read_stamp_nxt;
  logic                   seen_r, seen_nxt;

  logic [ANGLE_W-1:0]     angle_c;
  logic [ALPHA_W-1:0]     alpha_c;
  logic [ALPHA_W-1:0]     alpha_inv;
  logic [24:0]            prod_new;
  logic [24:0]            prod_old;
  logic [25:0]            ema_sum;
  logic [ANGLE_W-1:0]     sm_new;
  logic [TIME_BITS-1:0]   since_read;
  logic [TIME_BITS-1:0]   since_rep;
  logic                   too_soon;
  logic                   rep;
  logic                   partial;

  always_comb begin
    angle_c   = (item.angle > ANGLE_MAX) ? ANGLE_MAX : item.angle;
    alpha_c   = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
    alpha_inv = ALPHA_ONE - alpha_c;
    prod_new  = alpha_c * angle_c;
    prod_old  = alpha_inv * smoothed_r;
    // round half up before dropping the eight weight bits
    ema_sum   = {1'b0, prod_new} + {1'b0, prod_old} + 26'd128;
    sm_new    = sm_valid_r ? ema_sum[ANGLE_W+7:8] : angle_c;

    since_read = item.timestamp_ms - read_stamp_r;
    since_rep  = item.timestamp_ms - rep_stamp_r;
    too_soon   = rep_stamp_valid_r &&
                 (since_rep < {{(TIME_BITS-16){1'b0}}, cfg.min_interval_ms});
  end

  always_comb begin
    phase_nxt           = phase_r;
    sm_valid_nxt        = sm_valid_r;
    smoothed_nxt        = smoothed_r;
    rep_min_nxt         = rep_min_r;
    last_min_nxt        = last_min_r;
    rep_stamp_nxt       = rep_stamp_r;
    rep_stamp_valid_nxt = rep_stamp_valid_r;
    read_stamp_nxt      = read_stamp_r;
    seen_nxt            = seen_r;
    rep                 = 1'b0;
    partial             = 1'b0;

    if (item.req_type == REQ_RESTART) begin
      phase_nxt           = PH_UNKNOWN;
      sm_valid_nxt        = 1'b0;
      smoothed_nxt        = '0;
      rep_min_nxt         = ANGLE_MAX;
      last_min_nxt        = ANGLE_MAX;
      rep_stamp_nxt       = '0;
      rep_stamp_valid_nxt = 1'b0;
      read_stamp_nxt      = '0;
    end else if (!item.reading_valid) begin
      // tracking lost after too long without a reading
      if (sm_valid_r &&
          (since_read > {{(TIME_BITS-16){1'b0}}, cfg.lost_timeout_ms})) begin
        phase_nxt    = PH_UNKNOWN;
        sm_valid_nxt = 1'b0;
        rep_min_nxt  = ANGLE_MAX;
      end
    end else begin
      seen_nxt       = 1'b1;
      read_stamp_nxt = item.timestamp_ms;
      smoothed_nxt   = sm_new;
      sm_valid_nxt   = 1'b1;

      if (phase_r == PH_FLEXED && sm_new < rep_min_r) begin
        rep_min_nxt = sm_new;
      end

      if (sm_new < cfg.flex_threshold) begin
        if (phase_r != PH_FLEXED) begin
          phase_nxt   = PH_FLEXED;
          rep_min_nxt = sm_new;
        end
      end else if (sm_new > cfg.ext_threshold) begin
        phase_nxt = PH_EXTENDED;
        if (phase_r == PH_FLEXED && !too_soon) begin
          rep_stamp_nxt       = item.timestamp_ms;
          rep_stamp_valid_nxt = 1'b1;
          last_min_nxt        = rep_min_nxt;
          rep_min_nxt         = ANGLE_MAX;
          rep                 = 1'b1;
          partial             = last_min_nxt > cfg.partial_threshold;
        end
      end
    end
  end

  always_comb begin
    res.rep_done           = rep;
    res.partial_rep        = partial;
    res.phase              = phase_nxt;
    res.smoothed_angle     = smoothed_nxt;
    res.has_reading        = sm_valid_nxt;
    res.ever_seen          = seen_nxt;
    res.last_rep_min_angle = last_min_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_UNKNOWN;
      sm_valid_r        <= 1'b0;
      smoothed_r        <= '0;
      rep_min_r         <= ANGLE_MAX;
      last_min_r        <= ANGLE_MAX;
      rep_stamp_r       <= '0;
      rep_stamp_valid_r <= 1'b0;
      read_stamp_r      <= '0;
      seen_r            <= 1'b0;
    end else if (adv) begin
      phase_r           <= phase_nxt;
      sm_valid_r        <= sm_valid_nxt;
      smoothed_r        <= smoothed_nxt;
      rep_min_r         <= rep_min_nxt;
      last_min_r        <= last_min_nxt;
      rep_stamp_r       <= rep_stamp_nxt;
      rep_stamp_valid_r <= rep_stamp_valid_nxt;
      read_stamp_r      <= read_stamp_nxt;
      seen_r            <= seen_nxt;
    end
  end

  // a counted rep always leaves the phase extended
  a_rep_extended: assert property (@(posedge clk) disable iff (!rst_n)
    adv && rep |=> phase_r == PH_EXTENDED)
    else $error("rep counted without extended phase");

  // rep minimum is back at full scale after a counted rep
  a_rep_min_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    adv && rep |=> rep_min_r == ANGLE_MAX)
    else $error("rep minimum not cleared after rep");

  // no smoothing state survives a restart
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.req_type == REQ_RESTART |=> !sm_valid_r && !rep_stamp_valid_r)
    else $error("restart left tracking state");

endmodule

`default_nettype wire

// ----- design/hysteresis_rep_counter.sv -----
// top level of the hysteresis rep counter: input register, core and result register
// depends on hrc_pkg, hrc_cfg_regs and hrc_core
// Each accepted item (an angle sample, a missing reading or a restart) gives exactly one
// result. Items pass through an input register, the combinational update logic and a
// result register, and a result is valid once its item has moved from the input register
// into the result register; a new item is taken every cycle while in_stall is low. The
// single update step of the tracking state, with its EMA multiply, add and threshold
// compares, sits between the two registers. in_stall rises only when the result register
// is full and stalled. Configuration writes are taken at any time (cfg_ready is always
// high) but must be made while no item is in flight.
`default_nettype none

module hysteresis_rep_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic        in_reading_valid,
  input  logic [15:0] in_angle,
  input  logic [31:0] in_timestamp_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_rep_done,
  output logic        out_partial_rep,
  output logic [1:0]  out_phase,
  output logic [15:0] out_smoothed_angle,
  output logic        out_has_reading,
  output logic        out_ever_seen,
  output logic [15:0] out_last_rep_min_angle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import hrc_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_v_r;
  result_t res;
  result_t out_r;
  logic    out_v_r;
  logic    adv;
  logic    in_take;

  hrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  hrc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // the held item moves on when the result register is free or being emptied
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.req_type      <= in_req_type;
      in_item_r.reading_valid <= in_reading_valid;
      in_item_r.angle         <= in_angle;
      in_item_r.timestamp_ms  <= in_timestamp_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_v_r;
  assign out_rep_done           = out_r.rep_done;
  assign out_partial_rep        = out_r.partial_rep;
  assign out_phase              = out_r.phase;
  assign out_smoothed_angle     = out_r.smoothed_angle;
  assign out_has_reading        = out_r.has_reading;
  assign out_ever_seen          = out_r.ever_seen;
  assign out_last_rep_min_angle = out_r.last_rep_min_angle;

  // a partial flag only comes with a counted rep
  a_partial_needs_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_partial_rep |-> out_rep_done)
    else $error("partial rep without rep");

  // an item leaving the input register always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("result register not filled");

  // input side only stalls while the result side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_v_r && out_stall)
    else $error("input stalled without output stall");

endmodule

`default_nettype wire

// ----- tb/tb_hysteresis_rep_counter.sv -----
// self-checking testbench for hysteresis_rep_counter: directed items, then motion-like random items
// under several register settings; needs hrc_pkg and the design files only
`timescale 1ns / 1ps

module tb_hysteresis_rep_counter;
  import hrc_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 160;
  localparam int NUM_PHASES   = 8;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_req_type      = 1'b0;
  logic        in_reading_valid = 1'b0;
  logic [15:0] in_angle         = '0;
  logic [31:0] in_timestamp_ms  = '0;
  logic        out_stall        = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic [2:0]  cfg_index        = '0;
  logic [15:0] cfg_wdata        = '0;

  logic        in_stall;
  logic        out_valid;
  logic        out_rep_done;
  logic        out_partial_rep;
  logic [1:0]  out_phase;
  logic [15:0] out_smoothed_angle;
  logic        out_has_reading;
  logic        out_ever_seen;
  logic [15:0] out_last_rep_min_angle;
  logic        cfg_ready;

  hysteresis_rep_counter dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_req_type            (in_req_type),
    .in_reading_valid       (in_reading_valid),
    .in_angle               (in_angle),
    .in_timestamp_ms        (in_timestamp_ms),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_rep_done           (out_rep_done),
    .out_partial_rep        (out_partial_rep),
    .out_phase              (out_phase),
    .out_smoothed_angle     (out_smoothed_angle),
    .out_has_reading        (out_has_reading),
    .out_ever_seen          (out_ever_seen),
    .out_last_rep_min_angle (out_last_rep_min_angle),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  // tracks the rep counter state and holds the results still owed by the block
  class rep_count_board;
    logic [15:0] up_thr, down_thr, min_gap, lost_limit, partial_thr;
    logic [8:0]  alpha;
    phase_t      phase;
    logic        tracking, rep_ts_valid, seen;
    logic [15:0] smooth, rep_min, last_rep_min;
    logic [31:0] last_rep_ts, last_read_ts;
    result_t     due[$];
    int          errors;

    function new();
      up_thr      = 16'd40960;
      down_thr    = 16'd25600;
      min_gap     = 16'd500;
      lost_limit  = 16'd1000;
      alpha       = 9'd128;
      partial_thr = 16'd30720;
      seen        = 1'b0;
      errors      = 0;
      clear_tracking();
    endfunction

    function void clear_tracking();
      phase        = PH_UNKNOWN;
      tracking     = 1'b0;
      smooth       = '0;
      rep_min      = ANGLE_MAX;
      last_rep_min = ANGLE_MAX;
      last_rep_ts  = '0;
      rep_ts_valid = 1'b0;
      last_read_ts = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_UP_THR:      up_thr = val;
        REG_DOWN_THR:    down_thr = val;
        REG_MIN_INT:     min_gap = val;
        REG_LOST_TO:     lost_limit = val;
        REG_ALPHA:       alpha = val[8:0];
        REG_PARTIAL_THR: partial_thr = val;
        default: ;
      endcase
    endfunction

    function void track_item(item_t it);
      result_t     r;
      logic [8:0]  a;
      logic [15:0] ang;
      logic [31:0] acc;
      logic        completes;
      r = '0;
      if (it.req_type == REQ_RESTART) begin
        clear_tracking();
      end else if (!it.reading_valid) begin
        // differences wrap at 32 bits
        if (tracking && (it.timestamp_ms - last_read_ts) > 32'(lost_limit)) begin
          phase    = PH_UNKNOWN;
          tracking = 1'b0;
          rep_min  = ANGLE_MAX;
        end
      end else begin
        a            = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        ang          = (it.angle > ANGLE_MAX) ? ANGLE_MAX : it.angle;
        seen         = 1'b1;
        last_read_ts = it.timestamp_ms;
        if (tracking) begin
          acc    = 32'(a) * 32'(ang) + 32'(ALPHA_ONE - a) * 32'(smooth) + 32'd128;
          smooth = acc[23:8];
        end else begin
          smooth = ang;
        end
        tracking = 1'b1;
        if (phase == PH_FLEXED && smooth < rep_min) rep_min = smooth;
        if (smooth < down_thr) begin
          if (phase != PH_FLEXED) begin
            phase   = PH_FLEXED;
            rep_min = smooth;
          end
        end else if (smooth > up_thr) begin
          completes = (phase == PH_FLEXED);
          phase     = PH_EXTENDED;
          // debounce: a rep too soon after the last one is dropped
          if (completes &&
              !(rep_ts_valid && (it.timestamp_ms - last_rep_ts) < 32'(min_gap))) begin
            last_rep_ts   = it.timestamp_ms;
            rep_ts_valid  = 1'b1;
            last_rep_min  = rep_min;
            rep_min       = ANGLE_MAX;
            r.rep_done    = 1'b1;
            r.partial_rep = (last_rep_min > partial_thr);
          end
        end
      end
      r.phase              = phase;
      r.smoothed_angle     = smooth;
      r.has_reading        = tracking;
      r.ever_seen          = seen;
      r.last_rep_min_angle = last_rep_min;
      due.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      want = due.pop_front();
      check_field("rep_done", want.rep_done, got.rep_done);
      check_field("partial_rep", want.partial_rep, got.partial_rep);
      check_field("phase", want.phase, got.phase);
      check_field("smoothed_angle", want.smoothed_angle, got.smoothed_angle);
      check_field("has_reading", want.has_reading, got.has_reading);
      check_field("ever_seen", want.ever_seen, got.ever_seen);
      check_field("last_rep_min_angle", want.last_rep_min_angle, got.last_rep_min_angle);
    endfunction
  endclass

  rep_count_board board = new();
  int             idle_pct = 6;
  result_t        out_item;

  // motion generator state
  int          pos, lo_mark, hi_mark;
  bit          rising;
  logic [31:0] clock_ms;

  assign out_item = {out_rep_done, out_partial_rep, out_phase, out_smoothed_angle,
                     out_has_reading, out_ever_seen, out_last_rep_min_angle};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.match_result(out_item);
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic send_item(logic req, logic rv, logic [15:0] ang, logic [31:0] ts);
    item_t it;
    it.req_type      = req;
    it.reading_valid = rv;
    it.angle         = ang;
    it.timestamp_ms  = ts;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_reading_valid <= rv;
    in_angle         <= ang;
    in_timestamp_ms  <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.track_item(it);
  endtask

  // hold the sender off until every owed result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] up, dn, gap, lost, alpha_v, part);
    logic [15:0] v [6];
    logic [2:0]  idx [6];
    v   = '{up, dn, gap, lost, alpha_v, part};
    idx = '{REG_UP_THR, REG_DOWN_THR, REG_MIN_INT, REG_LOST_TO, REG_ALPHA, REG_PARTIAL_THR};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= v[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.write_reg(idx[i], v[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // turning points either side of the current thresholds, now and then a shallow turn
  task automatic pick_marks();
    lo_mark = int'(board.down_thr) - int'($urandom_range(0, 6000));
    hi_mark = int'(board.up_thr) + int'($urandom_range(0, 5000));
    if (lo_mark < 0) lo_mark = 0;
    if (hi_mark > 46080) hi_mark = 46080;
    if ($urandom_range(9) == 0) begin
      if (rising) hi_mark = (lo_mark + hi_mark) / 2;
      else lo_mark = (lo_mark + hi_mark) / 2;
    end
  endtask

  initial begin
    int          pick, a_val;
    logic [15:0] up, dn, ang;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset settings
    send_item(REQ_SAMPLE, 1'b0, 16'd0, 32'd0);        // miss before any reading
    send_item(REQ_RESTART, 1'b0, 16'd0, 32'd5);
    send_item(REQ_SAMPLE, 1'b1, 16'd0, 32'd10);       // first reading taken as is
    for (int i = 0; i < 4; i++) send_item(REQ_SAMPLE, 1'b1, 16'd46080, 32'(20 + 10 * i));
    send_item(REQ_SAMPLE, 1'b1, 16'hFFFF, 32'd60);    // saturated angle
    for (int i = 0; i < 3; i++) send_item(REQ_SAMPLE, 1'b1, 16'd0, 32'(70 + 10 * i));
    // back up too soon after the first rep
    for (int i = 0; i < 4; i++) send_item(REQ_SAMPLE, 1'b1, 16'd46080, 32'(100 + 10 * i));
    send_item(REQ_SAMPLE, 1'b0, 16'hFFFF, 32'd500);
    send_item(REQ_SAMPLE, 1'b0, 16'd0, 32'd1200);     // lost tracking
    send_item(REQ_SAMPLE, 1'b1, 16'd0, 32'd1210);
    send_item(REQ_SAMPLE, 1'b1, 16'd46080, 32'hFFFF_FFF0);
    send_item(REQ_SAMPLE, 1'b0, 16'd0, 32'h0000_0100); // wrapped, still in time
    send_item(REQ_SAMPLE, 1'b0, 16'd0, 32'h0000_0500); // wrapped, timed out
    send_item(REQ_RESTART, 1'b1, 16'd46080, 32'hFFFF_FFFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          1: write_regs(16'd46080, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0);
          2: write_regs(16'd0, 16'd46080, 16'd65535, 16'd65535, 16'd1, 16'd46080);
          3: write_regs(16'd36000, 16'd20000, 16'd300, 16'd800, 16'd0, 16'd15000);
          4: write_regs(16'd42000, 16'd12000, 16'd1000, 16'd400, 16'd511, 16'd8000);
          default: begin
            up = 16'($urandom_range(20000, 45000));
            dn = 16'($urandom_range(2000, up - 1000));
            write_regs(up, dn, 16'($urandom_range(0, 1500)), 16'($urandom_range(150, 3000)),
                       16'($urandom_range(24, 256)), 16'($urandom_range(0, 46080)));
          end
        endcase
      end
      idle_pct = (p == 5) ? 0 : 6;
      clock_ms = $urandom;
      pos      = int'($urandom_range(0, 46080));
      rising   = 1'($urandom_range(1));
      pick_marks();

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) settle();
        if ($urandom_range(99) < 3) clock_ms += $urandom_range(500, 70000);
        else clock_ms += $urandom_range(5, 120);
        pick = $urandom_range(99);
        if (pick < 80) begin
          if (rising) begin
            pos += int'($urandom_range(150, 2500));
            if (pos >= hi_mark) begin
              pos    = hi_mark;
              rising = 1'b0;
              pick_marks();
            end
          end else begin
            pos -= int'($urandom_range(150, 2500));
            if (pos <= lo_mark) begin
              pos    = lo_mark;
              rising = 1'b1;
              pick_marks();
            end
          end
          a_val = pos + int'($urandom_range(0, 600)) - 300;
          if (a_val < 0) a_val = 0;
          if (a_val > 46080) a_val = 46080;
          ang = 16'(a_val);
          send_item(REQ_SAMPLE, 1'b1, ang, clock_ms);
        end else if (pick < 88) begin
          send_item(REQ_SAMPLE, 1'b0, 16'($urandom), clock_ms);
        end else if (pick < 90) begin
          send_item(REQ_RESTART, 1'($urandom), 16'($urandom), clock_ms);
        end else begin
          // noise: any angle code, sometimes a stray timestamp
          send_item(REQ_SAMPLE, 1'b1, 16'($urandom),
                    $urandom_range(1) ? $urandom : clock_ms);
        end
      end
    end

    settle();
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/hrc_pkg.sv
design/hrc_cfg_regs.sv
design/hrc_core.sv
design/hysteresis_rep_counter.sv
tb/tb_hysteresis_rep_counter.sv
